[src/ec_pkg.sv]
// ec_pkg: shared types, constants, curve codes and lookup tables of the easing
// curve generator; used by every module in src
// no dependencies
package ec_pkg;

  localparam int TIME_BITS  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SINE_DEPTH = 256;
  localparam int EXP2_DEPTH = 256;
  localparam int FX_W       = 24;
  localparam int TAB_W      = 18;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t ONE_F  = fx_t'(1 << FRAC_BITS);
  localparam fx_t HALF_F = fx_t'(1 << (FRAC_BITS - 1));

  // back constants, Q30 rounded to nearest at the working fraction
  localparam longint unsigned C1_Q30 = 64'd1827057613;
  localparam longint unsigned C3_Q30 = 64'd2900799437;
  localparam longint unsigned C2_Q30 = 64'd2786262860;
  localparam fx_t BACK_C1 = fx_t'((C1_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  localparam fx_t BACK_C3 = fx_t'((C3_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  localparam fx_t BACK_C2 = fx_t'((C2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE  = 3'd0,
    REG_CHANGE = 3'd1,
    REG_BASE   = 3'd2,
    REG_DUR    = 3'd3
  } reg_e;

  typedef enum logic [4:0] {
    CV_IN_SINE    = 5'd0,
    CV_OUT_SINE   = 5'd1,
    CV_INOUT_SINE = 5'd2,
    CV_IN_QUAD    = 5'd3,
    CV_OUT_QUAD   = 5'd4,
    CV_INOUT_QUAD = 5'd5,
    CV_IN_CUBIC   = 5'd6,
    CV_OUT_CUBIC  = 5'd7,
    CV_INOUT_CUBIC= 5'd8,
    CV_IN_QUART   = 5'd9,
    CV_OUT_QUART  = 5'd10,
    CV_INOUT_QUART= 5'd11,
    CV_IN_QUINT   = 5'd12,
    CV_OUT_QUINT  = 5'd13,
    CV_INOUT_QUINT= 5'd14,
    CV_IN_EXPO    = 5'd15,
    CV_OUT_EXPO   = 5'd16,
    CV_IN_BACK    = 5'd17,
    CV_OUT_BACK   = 5'd18,
    CV_INOUT_BACK = 5'd19,
    CV_LINEAR     = 5'd20,
    CV_SMOOTH     = 5'd21
  } curve_e;

  typedef enum logic [1:0] {
    FM_IN    = 2'd0,
    FM_OUT   = 2'd1,
    FM_INOUT = 2'd2
  } form_e;

  // item handed from the divider side to the curve side
  typedef struct packed {
    logic [4:0]         sel;
    logic [FRAC_BITS:0] t;
    logic               clamped;
  } qi_t;

  typedef logic [TAB_W-1:0] sin_tab_t [0:SINE_DEPTH];
  typedef logic [TAB_W-1:0] exp_tab_t [0:EXP2_DEPTH];

  // shift and subtract quotient of a 32-bit dividend, used while building the tables
  function automatic longint unsigned udiv32(longint unsigned n, longint unsigned d);
    longint unsigned q, rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic sin_tab_t build_sin();
    sin_tab_t        tab;
    longint unsigned a, a2, mag;
    longint          sum;
    longint unsigned v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      a   = (longint'(i) * 64'd1686629713) / SINE_DEPTH;
      a2  = (a * a) >> 30;
      mag = a;
      sum = longint'(a);
      for (int k = 1; k <= 8; k++) begin
        mag = udiv32((mag * a2) >> 30, longint'((2 * k) * (2 * k + 1)));
        if ((k % 2) == 1) sum = sum - longint'(mag);
        else sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (v > (64'd1 << FRAC_BITS)) v = 64'd1 << FRAC_BITS;
      tab[i] = TAB_W'(v);
    end
    return tab;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t        tab;
    longint unsigned y, term, sum;
    for (int i = 0; i <= EXP2_DEPTH; i++) begin
      y    = (longint'(i) * 64'd744261118) / EXP2_DEPTH;
      term = 64'd1 << 30;
      sum  = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        term = udiv32((term * y) >> 30, longint'(k));
        sum  = sum + term;
      end
      tab[i] = TAB_W'((sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin();
  localparam exp_tab_t EXP_TAB = build_exp();

  // product of two fractions, round half up
  function automatic fx_t mulq(fx_t a, fx_t b);
    logic signed [2*FX_W-1:0] p;
    p = a * b;
    p = p + (2*FX_W)'(1 << (FRAC_BITS - 1));
    return fx_t'(p >>> FRAC_BITS);
  endfunction

  function automatic fx_t halfq(fx_t v);
    logic signed [FX_W:0] w;
    w = v + (FX_W+1)'(1);
    return fx_t'(w >>> 1);
  endfunction

  function automatic logic [2:0] poly_pow(logic [4:0] sel);
    case (sel) inside
      [CV_IN_QUAD:CV_INOUT_QUAD]:   return 3'd2;
      [CV_IN_CUBIC:CV_INOUT_CUBIC]: return 3'd3;
      [CV_IN_QUART:CV_INOUT_QUART]: return 3'd4;
      [CV_IN_QUINT:CV_INOUT_QUINT]: return 3'd5;
      default:                      return 3'd0;
    endcase
  endfunction

  function automatic form_e poly_form(logic [4:0] sel);
    case (sel) inside
      CV_IN_QUAD, CV_IN_CUBIC, CV_IN_QUART, CV_IN_QUINT:     return FM_IN;
      CV_OUT_QUAD, CV_OUT_CUBIC, CV_OUT_QUART, CV_OUT_QUINT: return FM_OUT;
      default:                                               return FM_INOUT;
    endcase
  endfunction

endpackage

[src/ec_front.sv]
// ec_front: clamps elapsed time and forms t = elapsed / duration with a
// pipelined restoring divider, one quotient bit per stage; uses ec_pkg
module ec_front import ec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TIME_BITS-1:0] elapsed_ticks_i,
  input  logic [4:0]           curve_select_i,
  input  logic [TIME_BITS-1:0] duration_ticks_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qi_t                  out_item_o
);

  localparam int NST = FRAC_BITS + 1;

  typedef struct packed {
    logic [4:0]           sel;
    logic [TIME_BITS-1:0] dv;
    logic [TIME_BITS:0]   rem;
    logic [FRAC_BITS:0]   quo;
    logic                 clamped;
  } fr_t;

  logic [NST-1:0] vld_q;
  logic [NST:0]   en;
  fr_t            stg_q [NST];
  fr_t            stg_d [NST];

  always_comb begin
    en[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    logic [TIME_BITS-1:0] dv;
    logic [TIME_BITS-1:0] ev;
    logic [TIME_BITS:0]   r2;
    dv = (duration_ticks_i == '0) ? TIME_BITS'(1) : duration_ticks_i;
    ev = elapsed_ticks_i;
    stg_d[0].sel     = curve_select_i;
    stg_d[0].dv      = dv;
    stg_d[0].clamped = ev > dv;
    if (ev > dv) ev = dv;
    // whole part of the quotient is 1 only when elapsed reaches duration
    stg_d[0].quo = '0;
    if (ev == dv) begin
      stg_d[0].quo[FRAC_BITS] = 1'b1;
      stg_d[0].rem            = '0;
    end else begin
      stg_d[0].rem = {1'b0, ev};
    end
    for (int k = 1; k < NST; k++) begin
      stg_d[k] = stg_q[k-1];
      r2 = {stg_q[k-1].rem[TIME_BITS-1:0], 1'b0};
      if (r2 >= {1'b0, stg_q[k-1].dv}) begin
        stg_d[k].rem = r2 - {1'b0, stg_q[k-1].dv};
        stg_d[k].quo[FRAC_BITS-k] = 1'b1;
      end else begin
        stg_d[k].rem = r2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_stall_o          = !en[0];
  assign out_valid_o         = vld_q[NST-1];
  assign out_item_o.sel      = stg_q[NST-1].sel;
  assign out_item_o.t        = stg_q[NST-1].quo;
  assign out_item_o.clamped  = stg_q[NST-1].clamped;

endmodule

[src/ec_queue.sv]
// ec_queue: four-entry register queue between the divider and the curve
// pipeline; uses ec_pkg
module ec_queue import ec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  qi_t  in_item_i,
  output logic out_valid_o,
  input  logic out_take_i,
  output qi_t  out_item_o
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  qi_t         buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != (PW+1)'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_take_i && out_valid_o;
  assign out_item_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

[src/ec_back.sv]
// ec_back: curve pipeline; table lookups, power chain, back and smoothstep
// terms, curve select, scaling by change, offset and saturation; uses ec_pkg
module ec_back import ec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_take_o,
  input  qi_t                in_item_i,
  input  logic signed [31:0] change_i,
  input  logic signed [31:0] base_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] eased_value_o,
  output logic               time_clamped_o,
  output logic               value_saturated_o
);

  localparam int NST = 9;

  typedef struct packed {
    logic [4:0]         sel;
    logic [FRAC_BITS:0] t;
    logic               clamped;
    logic               half_lo;
    fx_t                x;
    fx_t                sa;
    fx_t                sb;
    fx_t                sr;
    fx_t                ea;
    fx_t                eb;
    fx_t                er;
    logic [3:0]         ek;
    fx_t                p1;
    fx_t                p2;
    fx_t                p3;
    fx_t                p4;
    fx_t                sin_v;
    fx_t                exp_m;
    fx_t                exp_v;
    fx_t                kx;
    fx_t                three_m;
    fx_t                c1x2;
    fx_t                c3x3;
    fx_t                gv;
    fx_t                ssv;
    fx_t                hv;
    fx_t                ease;
    logic signed [55:0] prod;
    logic signed [31:0] sum;
    logic               sat;
  } bk_t;

  logic [NST-1:0] vld_q;
  logic [NST:0]   en;
  bk_t            stg_q [NST];
  bk_t            stg_d [NST];

  always_comb begin
    en[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_take_o = en[0];

  always_comb begin
    fx_t                tf, sf, dbl, r, sdif;
    logic [FRAC_BITS:0] sarg;
    logic [19:0]        ev;
    logic [19:0]        ud;
    logic [3:0]         kk;
    logic [8:0]         ui;
    logic [18:0]        mm;
    logic [2:0]         pw;
    logic signed [40:0] acc;

    // stage 0: item from the queue
    stg_d[0]         = '0;
    stg_d[0].sel     = in_item_i.sel;
    stg_d[0].t       = in_item_i.t;
    stg_d[0].clamped = in_item_i.clamped;

    // stage 1: operand choice and table reads
    stg_d[1] = stg_q[0];
    tf = fx_t'({1'b0, stg_q[0].t});
    sf = ONE_F - tf;
    stg_d[1].half_lo = tf < HALF_F;
    dbl = stg_d[1].half_lo ? (tf <<< 1) : (sf <<< 1);
    case (stg_q[0].sel) inside
      [CV_IN_QUAD:CV_INOUT_QUINT]: begin
        case (poly_form(stg_q[0].sel))
          FM_IN:   stg_d[1].x = tf;
          FM_OUT:  stg_d[1].x = sf;
          default: stg_d[1].x = dbl;
        endcase
      end
      CV_OUT_BACK:   stg_d[1].x = sf;
      CV_INOUT_BACK: stg_d[1].x = dbl;
      default:       stg_d[1].x = tf;
    endcase
    sdif = stg_d[1].half_lo ? (ONE_F - (tf <<< 1)) : ((tf <<< 1) - ONE_F);
    case (stg_q[0].sel)
      CV_IN_SINE:    sarg = sf[FRAC_BITS:0];
      CV_INOUT_SINE: sarg = sdif[FRAC_BITS:0];
      default:       sarg = stg_q[0].t;
    endcase
    if (sarg[FRAC_BITS]) begin
      stg_d[1].sa = fx_t'(SIN_TAB[SINE_DEPTH]);
      stg_d[1].sb = fx_t'(SIN_TAB[SINE_DEPTH]);
      stg_d[1].sr = '0;
    end else begin
      stg_d[1].sa = fx_t'(SIN_TAB[{1'b0, sarg[15:8]}]);
      stg_d[1].sb = fx_t'(SIN_TAB[{1'b0, sarg[15:8]} + 9'd1]);
      stg_d[1].sr = fx_t'({sarg[7:0], 8'b0});
    end
    // 2^-v with v = 10(1-t) or 10t: ceiling shift plus table on the fraction
    if (stg_q[0].sel == CV_IN_EXPO) ev = 20'(sf) * 20'd10;
    else ev = 20'(stg_q[0].t) * 20'd10;
    kk = 4'((ev + 20'd65535) >> FRAC_BITS);
    ud = (20'(kk) << FRAC_BITS) - ev;
    ui = {1'b0, ud[15:8]};
    stg_d[1].ek = kk;
    stg_d[1].ea = fx_t'(EXP_TAB[ui]);
    stg_d[1].eb = fx_t'(EXP_TAB[ui + 9'd1]);
    stg_d[1].er = fx_t'({ud[7:0], 8'b0});

    // stage 2: square, interpolation, linear back and smoothstep terms
    stg_d[2]         = stg_q[1];
    stg_d[2].p1      = mulq(stg_q[1].x, stg_q[1].x);
    stg_d[2].sin_v   = stg_q[1].sa + mulq(stg_q[1].sb - stg_q[1].sa, stg_q[1].sr);
    stg_d[2].exp_m   = stg_q[1].ea + mulq(stg_q[1].eb - stg_q[1].ea, stg_q[1].er);
    stg_d[2].kx      = mulq(BACK_C2 + ONE_F, stg_q[1].x);
    stg_d[2].three_m = fx_t'(3 * (1 << FRAC_BITS)) - (fx_t'({1'b0, stg_q[1].t}) <<< 1);

    // stage 3: cube, back and smoothstep products, expo scaling
    stg_d[3]      = stg_q[2];
    stg_d[3].p2   = mulq(stg_q[2].p1, stg_q[2].x);
    stg_d[3].c1x2 = mulq(BACK_C1, stg_q[2].p1);
    stg_d[3].gv   = halfq(mulq(stg_q[2].p1, stg_q[2].kx - BACK_C2));
    stg_d[3].ssv  = mulq(stg_q[2].p1, stg_q[2].three_m);
    mm = stg_q[2].exp_m[18:0] + (19'd1 << (stg_q[2].ek - 4'd1));
    if (stg_q[2].ek == '0) begin
      stg_d[3].exp_v = stg_q[2].exp_m;
    end else begin
      stg_d[3].exp_v = fx_t'(mm >> stg_q[2].ek);
    end

    // stage 4: fourth power, cubic back term
    stg_d[4]      = stg_q[3];
    stg_d[4].p3   = mulq(stg_q[3].p2, stg_q[3].x);
    stg_d[4].c3x3 = mulq(BACK_C3, stg_q[3].p2);

    // stage 5: fifth power, back h
    stg_d[5]    = stg_q[4];
    stg_d[5].p4 = mulq(stg_q[4].p3, stg_q[4].x);
    stg_d[5].hv = stg_q[4].c3x3 - stg_q[4].c1x2;

    // stage 6: curve select
    stg_d[6] = stg_q[5];
    tf = fx_t'({1'b0, stg_q[5].t});
    pw = poly_pow(stg_q[5].sel);
    case (pw)
      3'd2:    r = stg_q[5].p1;
      3'd3:    r = stg_q[5].p2;
      3'd4:    r = stg_q[5].p3;
      default: r = stg_q[5].p4;
    endcase
    case (stg_q[5].sel) inside
      [CV_IN_QUAD:CV_INOUT_QUINT]: begin
        case (poly_form(stg_q[5].sel))
          FM_IN:   stg_d[6].ease = r;
          FM_OUT:  stg_d[6].ease = ONE_F - r;
          default: stg_d[6].ease = stg_q[5].half_lo ? halfq(r) : ONE_F - halfq(r);
        endcase
      end
      CV_IN_SINE:    stg_d[6].ease = ONE_F - stg_q[5].sin_v;
      CV_OUT_SINE:   stg_d[6].ease = stg_q[5].sin_v;
      CV_INOUT_SINE: stg_d[6].ease = stg_q[5].half_lo ? halfq(ONE_F - stg_q[5].sin_v)
                                                      : halfq(ONE_F + stg_q[5].sin_v);
      CV_IN_EXPO:    stg_d[6].ease = (tf == '0) ? '0 : stg_q[5].exp_v;
      CV_OUT_EXPO:   stg_d[6].ease = (tf == ONE_F) ? ONE_F : ONE_F - stg_q[5].exp_v;
      CV_IN_BACK:    stg_d[6].ease = stg_q[5].hv;
      CV_OUT_BACK:   stg_d[6].ease = ONE_F - stg_q[5].hv;
      CV_INOUT_BACK: stg_d[6].ease = stg_q[5].half_lo ? stg_q[5].gv : ONE_F - stg_q[5].gv;
      CV_SMOOTH:     stg_d[6].ease = stg_q[5].ssv;
      default:       stg_d[6].ease = tf;
    endcase

    // stage 7: scale by change
    stg_d[7]      = stg_q[6];
    stg_d[7].prod = 56'(change_i) * 56'(stg_q[6].ease);

    // stage 8: round, offset, saturate
    stg_d[8] = stg_q[7];
    acc = 41'(base_i) + 41'((stg_q[7].prod + 56'sd32768) >>> FRAC_BITS);
    if (acc > 41'sd2147483647) begin
      stg_d[8].sum = 32'sh7fffffff;
      stg_d[8].sat = 1'b1;
    end else if (acc < -41'sd2147483648) begin
      stg_d[8].sum = 32'sh80000000;
      stg_d[8].sat = 1'b1;
    end else begin
      stg_d[8].sum = acc[31:0];
      stg_d[8].sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_valid_o       = vld_q[NST-1];
  assign eased_value_o     = stg_q[NST-1].sum;
  assign time_clamped_o    = stg_q[NST-1].clamped;
  assign value_saturated_o = stg_q[NST-1].sat;

endmodule

[src/easing_curve_generator_top.sv]
// easing_curve_generator_top: configuration registers, divider front end,
// queue and curve pipeline; uses ec_pkg, ec_front, ec_queue, ec_back
// 17 divider stages, the queue and 9 curve stages; the last stage drives the outputs
// throughput: one item per cycle while out_stall_i is low; each stage holds one item,
//   the queue absorbs stalls
// reset: asynchronous active low; clears pipeline valids, curve 0, change 0,
//   base 0, duration 1
module easing_curve_generator_top import ec_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TIME_BITS-1:0] elapsed_ticks_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   eased_value_o,
  output logic                 time_clamped_o,
  output logic                 value_saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [4:0]           curve_q;
  logic signed [31:0]   change_q;
  logic signed [31:0]   base_q;
  logic [TIME_BITS-1:0] dur_q;

  logic fq_valid, fq_ready, qb_valid, qb_take;
  qi_t  fq_item, qb_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q  <= CV_IN_SINE;
      change_q <= '0;
      base_q   <= '0;
      dur_q    <= TIME_BITS'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CURVE:  curve_q  <= cfg_data_i[4:0];
        REG_CHANGE: change_q <= cfg_data_i;
        REG_BASE:   base_q   <= cfg_data_i;
        REG_DUR:    dur_q    <= cfg_data_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  ec_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .elapsed_ticks_i  (elapsed_ticks_i),
    .curve_select_i   (curve_q),
    .duration_ticks_i (dur_q),
    .out_valid_o      (fq_valid),
    .out_ready_i      (fq_ready),
    .out_item_o       (fq_item)
  );

  ec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_item_i   (fq_item),
    .out_valid_o (qb_valid),
    .out_take_i  (qb_take),
    .out_item_o  (qb_item)
  );

  ec_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (qb_valid),
    .in_take_o         (qb_take),
    .in_item_i         (qb_item),
    .change_i          (change_q),
    .base_i            (base_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .eased_value_o     (eased_value_o),
    .time_clamped_o    (time_clamped_o),
    .value_saturated_o (value_saturated_o)
  );

endmodule

[tb/tb_easing_curve_generator_top.sv]
// tb_easing_curve_generator_top: self-checking bench for the easing curve generator;
// predicts every result in fixed point and checks it through the valid/stall ports
// depends on src/ec_pkg.sv and src/easing_curve_generator_top.sv
`timescale 1ns / 100ps

module tb_easing_curve_generator_top;
  import ec_pkg::*;

  localparam longint UNIT = 64'sd1 << FRAC_BITS;
  localparam longint HALF_UNIT = UNIT >>> 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [31:0] value;
    logic               clamped;
    logic               sat;
  } ease_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [TIME_BITS-1:0] elapsed_ticks_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [31:0]   eased_value_o;
  logic                 time_clamped_o;
  logic                 value_saturated_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  easing_curve_generator_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the configuration registers
  logic [4:0] cur_curve;
  longint     cur_change, cur_base;
  int         cur_dur;

  longint sine_lut [0:SINE_DEPTH];
  longint exp2_lut [0:EXP2_DEPTH];

  ease_res_t pending_q[$];
  int fails = 0, items_sent = 0, results_seen = 0, cfg_writes = 0;
  int send_idle_pct = 0, recv_idle_pct = 0, hold_off = 0;

  function automatic longint round_sh(longint p, int sh);
    return (p + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return round_sh(a * b, FRAC_BITS);
  endfunction

  function automatic longint fhalf(longint v);
    return round_sh(v, 1);
  endfunction

  function automatic longint from_q30(longint unsigned v);
    return longint'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  endfunction

  task automatic fill_luts();
    longint unsigned a, a2, mag, y, term, acc;
    longint sum;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      a = (longint'(i) * 64'd1686629713) / SINE_DEPTH;
      a2 = (a * a) >> 30;
      mag = a;
      sum = longint'(a);
      for (int k = 1; k <= 8; k++) begin
        mag = ((mag * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(mag);
        else sum += longint'(mag);
      end
      if (sum < 0) sum = 0;
      sine_lut[i] = from_q30(longint'(sum));
      if (sine_lut[i] > UNIT) sine_lut[i] = UNIT;
    end
    for (int i = 0; i <= EXP2_DEPTH; i++) begin
      y = (longint'(i) * 64'd744261118) / EXP2_DEPTH;
      term = 64'd1 << 30;
      acc = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * y) >> 30) / longint'(k);
        acc += term;
      end
      exp2_lut[i] = from_q30(acc);
    end
  endtask

  // linear interpolation in either table
  function automatic longint interp(bit use_exp, longint x);
    longint depth, pos, idx, r, lo, hi;
    depth = use_exp ? EXP2_DEPTH : SINE_DEPTH;
    pos = x * depth;
    idx = pos >>> FRAC_BITS;
    r = pos & (UNIT - 1);
    if (idx >= depth) return use_exp ? exp2_lut[depth] : sine_lut[depth];
    lo = use_exp ? exp2_lut[idx] : sine_lut[idx];
    hi = use_exp ? exp2_lut[idx + 1] : sine_lut[idx + 1];
    return lo + round_sh((hi - lo) * r, FRAC_BITS);
  endfunction

  // 2^-v for v >= 0
  function automatic longint exp2_neg(longint v);
    longint k, m;
    k = (v + UNIT - 1) >>> FRAC_BITS;
    m = interp(1'b1, k * UNIT - v);
    if (k == 0) return m;
    if (k > 40) return 0;
    return (m + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint fpow(longint x, int n);
    longint r;
    r = x;
    for (int i = 1; i < n; i++) r = fmul(r, x);
    return r;
  endfunction

  function automatic longint back_in(longint x);
    return fmul(from_q30(64'd2900799437), fpow(x, 3)) - fmul(from_q30(64'd1827057613), fmul(x, x));
  endfunction

  function automatic longint back_half(longint w);
    longint c2;
    c2 = from_q30(64'd2786262860);
    return fhalf(fmul(fmul(w, w), fmul(c2 + UNIT, w) - c2));
  endfunction

  function automatic longint curve_at(logic [4:0] sel, longint t);
    longint s, c;
    int n, form;
    s = UNIT - t;
    if (sel >= CV_IN_QUAD && sel <= CV_INOUT_QUINT) begin
      n = 2 + (sel - CV_IN_QUAD) / 3;
      form = (sel - CV_IN_QUAD) % 3;
      if (form == 0) return fpow(t, n);
      if (form == 1) return UNIT - fpow(s, n);
      if (t < HALF_UNIT) return fhalf(fpow(2 * t, n));
      return UNIT - fhalf(fpow(2 * s, n));
    end
    case (sel)
      CV_IN_SINE: return UNIT - interp(1'b0, s);
      CV_OUT_SINE: return interp(1'b0, t);
      CV_INOUT_SINE: begin
        c = (t < HALF_UNIT) ? interp(1'b0, UNIT - 2 * t) : -interp(1'b0, 2 * t - UNIT);
        return fhalf(UNIT - c);
      end
      CV_IN_EXPO: return (t == 0) ? 0 : exp2_neg(10 * UNIT - 10 * t);
      CV_OUT_EXPO: return (t == UNIT) ? UNIT : UNIT - exp2_neg(10 * t);
      CV_IN_BACK: return back_in(t);
      CV_OUT_BACK: return UNIT - back_in(s);
      CV_INOUT_BACK: return (t < HALF_UNIT) ? back_half(2 * t) : UNIT - back_half(2 * s);
      CV_SMOOTH: return fmul(fmul(t, t), 3 * UNIT - 2 * t);
      default: return t;
    endcase
  endfunction

  function automatic ease_res_t predict_ease(logic [TIME_BITS-1:0] elapsed);
    ease_res_t res;
    longint d, e, t, sum;
    d = (cur_dur == 0) ? 1 : cur_dur;
    e = elapsed;
    res.clamped = e > d;
    if (res.clamped) e = d;
    t = (e <<< FRAC_BITS) / d;
    sum = cur_base + round_sh(cur_change * curve_at(cur_curve, t), FRAC_BITS);
    res.sat = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      res.sat = 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = sum[31:0];
    return res;
  endfunction

  // valid stays high after a transfer so that items can follow back to back
  task automatic send_item(logic [TIME_BITS-1:0] elapsed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_ticks_i <= elapsed;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(predict_ease(elapsed));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CURVE: cur_curve = data[4:0];
      REG_CHANGE: cur_change = longint'(signed'(data));
      REG_BASE: cur_base = longint'(signed'(data));
      REG_DUR: cur_dur = data[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic setup(logic [4:0] curve, logic [31:0] change, logic [31:0] base,
                       logic [15:0] dur);
    drain();
    write_reg(REG_CURVE, {27'($urandom_range(2**27 - 1)), curve});
    write_reg(REG_CHANGE, change);
    write_reg(REG_BASE, base);
    write_reg(REG_DUR, {16'($urandom), dur});
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stall, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    ease_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result with no transfer outstanding: value %0d", eased_value_o);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (eased_value_o !== want.value) begin
          $error("eased_value expected %0d actual %0d", want.value, eased_value_o);
          fails++;
        end
        if (time_clamped_o !== want.clamped) begin
          $error("time_clamped expected %0b actual %0b", want.clamped, time_clamped_o);
          fails++;
        end
        if (value_saturated_o !== want.sat) begin
          $error("value_saturated expected %0b actual %0b", want.sat, value_saturated_o);
          fails++;
        end
      end
    end
  end

  task automatic test_directed();
    setup(CV_LINEAR, 32'd1000000, -32'sd5, 16'd65535);
    send_item(16'd0);
    send_item(16'hFFFF);
    send_item(16'h8000);
    setup(CV_IN_EXPO, 32'h7FFFFFFF, 32'h80000000, 16'd1);
    send_item(16'd0);
    send_item(16'd1);
    send_item(16'hFFFF);
    setup(CV_OUT_EXPO, 32'h80000000, 32'h7FFFFFFF, 16'd0);
    send_item(16'd0);
    send_item(16'd1);
    send_item(16'd2);
    // in-out split right at one half
    setup(CV_INOUT_BACK, 32'd1000000, 32'd0, 16'd2);
    send_item(16'd1);
    send_item(16'd0);
    setup(CV_INOUT_SINE, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd2);
    send_item(16'd1);
    send_item(16'd2);
    setup(CV_OUT_BACK, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd100);
    send_item(16'd60);
    setup(CV_IN_BACK, 32'h7FFFFFFF, 32'h80000000, 16'd100);
    send_item(16'd30);
    setup(5'd31, 32'd12345, 32'd7, 16'd10);
    send_item(16'd5);
    drain();
    write_reg(REG_UNUSED_LO, 32'hFFFFFFFF);
    write_reg(REG_UNUSED_HI, 32'h12345678);
    cfg_valid_i <= 1'b0;
    send_item(16'd9);
    setup(CV_SMOOTH, 32'd65536, 32'd0, 16'd4);
    send_item(16'd1);
    send_item(16'd3);
  endtask

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(int n_items);
    logic [15:0] dur;
    logic [15:0] e;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(4))
          0: dur = 16'hFFFF;
          1: dur = 16'($urandom_range(3));
          default: dur = 16'($urandom_range(1, 400));
        endcase
        setup(($urandom_range(9) == 0) ? 5'($urandom_range(22, 31)) : 5'($urandom_range(21)),
              pick_wide(), pick_wide(), dur);
      end
      if ($urandom_range(7) == 0) e = 16'($urandom);
      else e = 16'($urandom_range(cur_dur + 2));
      send_item(e);
    end
  endtask

  task automatic test_backpressure();
    setup(CV_OUT_QUINT, 32'd5000000, 32'd17, 16'd500);
    send_idle_pct = 0;
    hold_off = 400;
    for (int i = 0; i < 150; i++) send_item(16'($urandom_range(600)));
  endtask

  initial begin
    fill_luts();
    cur_curve = CV_IN_SINE;
    cur_change = 0;
    cur_base = 0;
    cur_dur = 1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 22;
    recv_idle_pct = 87;
    test_random(510);
    send_idle_pct = 87;
    recv_idle_pct = 22;
    test_random(510);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(510);
    test_backpressure();
    drain();
    $display("covered all curve codes, register extremes and long output hold-off");
    $display("%0d transfers in, %0d results, %0d register writes",
             items_sent, results_seen, cfg_writes);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
src/ec_pkg.sv
src/ec_front.sv
src/ec_queue.sv
src/ec_back.sv
src/easing_curve_generator_top.sv
tb/tb_easing_curve_generator_top.sv
